FILE: rtl/utf8d_pkg.sv
// Shared widths, byte-class masks and skip-state codes for the UTF-8 byte decoder.
package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 31;
   localparam int CNT_W  = 3;

   // Byte-class masks and their match patterns
   localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;
   localparam logic [BYTE_W-1:0] TOP_BIT      = 8'h80;
   localparam logic [BYTE_W-1:0] MASK_C0      = 8'hC0;
   localparam logic [BYTE_W-1:0] MASK_E0      = 8'hE0;
   localparam logic [BYTE_W-1:0] MASK_F0      = 8'hF0;
   localparam logic [BYTE_W-1:0] MASK_F8      = 8'hF8;
   localparam logic [BYTE_W-1:0] MASK_FC      = 8'hFC;
   localparam logic [BYTE_W-1:0] MASK_FE      = 8'hFE;

   // Continuation bytes still expected after each lead form
   localparam logic [CNT_W-1:0] CONT_2B = 3'd1;
   localparam logic [CNT_W-1:0] CONT_3B = 3'd2;
   localparam logic [CNT_W-1:0] CONT_4B = 3'd3;
   localparam logic [CNT_W-1:0] CONT_5B = 3'd4;
   localparam logic [CNT_W-1:0] CONT_6B = 3'd5;

   // Run-absorbing state after an error
   typedef enum logic [2:0] {
      SKIP_NONE = 3'b001,
      SKIP_CONT = 3'b010,
      SKIP_HIGH = 3'b100
   } skip_type;

endpackage

FILE: rtl/utf8d_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
interface utf8d_req_if
   import utf8d_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface utf8d_rsp_if
   import utf8d_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            is_error;
   logic            is_ascii;

   modport source (output valid, output code_point, output is_error, output is_ascii,
                   input ready);
   modport sink   (input valid, input code_point, input is_error, input is_ascii,
                   output ready);
endinterface

FILE: rtl/utf8_byte_stream_decoder_unit.sv
// UTF-8 byte stream decoder (one to six byte forms) with input and result registers.
// A byte passes the input register, the single decode step and then the result
// register. Throughput: one byte per cycle while the result register is empty or
// being taken; output back-pressure stalls the input register.
// Reset (synchronous, active high) clears both valid flags, the gathered
// code point bits, the pending count and the skip state; no clearing pass.
module utf8_byte_stream_decoder_unit
   import utf8d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   utf8d_req_if.sink     req_chan,
   utf8d_rsp_if.source   rsp_chan
);

   // Input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Decoder state
   logic [CP_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   skip_type          skip_ff, skip_in;

   // Result register
   logic              out_valid_ff;
   logic [CP_W-1:0]   out_cp_ff;
   logic              out_err_ff;
   logic              out_ascii_ff;

   // Decode results
   logic              res_valid;
   logic [CP_W-1:0]   res_cp;
   logic              res_err;
   logic              res_ascii;
   logic              is_cont;
   logic              is_high;
   logic              absorb;

   logic              out_free;
   logic              step;
   logic              in_ready;

   // Handshake: result register frees when empty or being taken
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && out_free;
   assign in_ready = !in_valid_ff || out_free;
   assign req_chan.ready = in_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_ready && req_chan.valid) begin
         in_byte_ff <= req_chan.byte_in;
      end
   end

   // Byte classes
   assign is_cont = (in_byte_ff & MASK_C0) == TOP_BIT;
   assign is_high = (in_byte_ff & MASK_FE) == MASK_FE;

   // Absorb test for a run of the kind being skipped
   always_comb begin
      unique case (skip_ff)
         SKIP_CONT: absorb = is_cont;
         SKIP_HIGH: absorb = is_high;
         SKIP_NONE: absorb = 1'b0;
         default:   absorb = 1'b0;
      endcase
   end

   // Single decode step
   always_comb begin
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      skip_in   = skip_ff;
      res_valid = 1'b0;
      res_cp    = '0;
      res_err   = 1'b0;
      res_ascii = 1'b0;
      if (rem_ff != '0) begin
         // continuation expected: take the low six bits whatever the byte
         rem_in = rem_ff - CNT_W'(1);
         if (rem_ff == CNT_W'(1)) begin
            res_valid = 1'b1;
            res_cp    = {acc_ff[CP_W-7:0], in_byte_ff[5:0]};
            acc_in    = '0;
         end else begin
            acc_in = {acc_ff[CP_W-7:0], in_byte_ff[5:0]};
         end
      end else if (!absorb) begin
         skip_in = SKIP_NONE;
         if ((in_byte_ff & TOP_BIT) == '0) begin
            res_valid = 1'b1;
            res_ascii = 1'b1;
            res_cp    = CP_W'(in_byte_ff);
            acc_in    = '0;
         end else if (is_cont) begin
            // stray continuation: one error, then absorb the run
            skip_in   = SKIP_CONT;
            res_valid = 1'b1;
            res_err   = 1'b1;
            acc_in    = '0;
         end else if ((in_byte_ff & MASK_E0) == MASK_C0) begin
            acc_in = CP_W'(in_byte_ff[4:0]);
            rem_in = CONT_2B;
         end else if ((in_byte_ff & MASK_F0) == MASK_E0) begin
            acc_in = CP_W'(in_byte_ff[3:0]);
            rem_in = CONT_3B;
         end else if ((in_byte_ff & MASK_F8) == MASK_F0) begin
            acc_in = CP_W'(in_byte_ff[2:0]);
            rem_in = CONT_4B;
         end else if ((in_byte_ff & MASK_FC) == MASK_F8) begin
            acc_in = CP_W'(in_byte_ff[1:0]);
            rem_in = CONT_5B;
         end else if ((in_byte_ff & MASK_FE) == MASK_FC) begin
            acc_in = CP_W'(in_byte_ff[0]);
            rem_in = CONT_6B;
         end else begin
            // 0xFE/0xFF: one error, then absorb the run
            skip_in   = SKIP_HIGH;
            res_valid = 1'b1;
            res_err   = 1'b1;
            acc_in    = '0;
         end
      end
   end

   // Decoder state update, once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         skip_ff <= SKIP_NONE;
      end else if (step) begin
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         skip_ff <= skip_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && res_valid;
      end
      if (step && res_valid) begin
         out_cp_ff    <= res_cp;
         out_err_ff   <= res_err;
         out_ascii_ff <= res_ascii;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_cp_ff;
   assign rsp_chan.is_error   = out_err_ff;
   assign rsp_chan.is_ascii   = out_ascii_ff;

endmodule
